/* rtl/htw_pkg.sv */
package htw_pkg;

    typedef enum logic [2:0] {
        REQ_TICK    = 3'd0,
        REQ_ADD_ONE = 3'd1,
        REQ_ADD_REP = 3'd2,
        REQ_REMOVE  = 3'd3,
        REQ_RESTART = 3'd4,
        REQ_MODIFY  = 3'd5,
        REQ_CLEAR   = 3'd6
    } req_t;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_BAD_TMO = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;
    localparam logic [1:0] ST_NOT_RUN = 2'd3;

    localparam logic KIND_ACK    = 1'b0;
    localparam logic KIND_EXPIRY = 1'b1;

    localparam logic CFG_TICK_INTERVAL = 1'b0;
    localparam logic CFG_MAX_TIMEOUT   = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_TREAD,
        S_TCHK,
        S_DIV,
        S_WRITE,
        S_ACK,
        S_FLUSH
    } state_t;

    typedef struct packed {
        logic        start;
        logic [15:0] dividend;
        logic [9:0]  divisor;
    } div_req_t;

endpackage

/* rtl/htw_ram.sv */
module htw_ram #(
    parameter int DEPTH = 32,
    parameter int AW    = 5,
    parameter int DW    = 57
) (
    input  logic          clk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [DW-1:0] wr_data,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output logic [DW-1:0] rd_data
);

    logic [DW-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

/* rtl/htw_div.sv */
module htw_div #(
    parameter int SW         = 8,
    parameter int SLOT_COUNT = 256
) (
    input  logic              clk,
    input  logic              rst_n,
    input  htw_pkg::div_req_t req,
    input  logic [SW-1:0]     cur,
    output logic              done,
    output logic [SW-1:0]     slot
);
    import htw_pkg::*;

    localparam logic [SW:0] W_EXT = (SW + 1)'(SLOT_COUNT);

    logic          busy_reg, busy_next;
    logic          fin_reg, fin_next;
    logic          done_reg, done_next;
    logic [3:0]    cnt_reg;
    logic [15:0]   dvd_reg;
    logic [9:0]    dsr_reg;
    logic [9:0]    rem_reg;
    logic [SW-1:0] qmod_reg;
    logic          qnz_reg;
    logic [SW-1:0] cur_reg;
    logic [SW-1:0] slot_reg;

    logic [10:0]   t;
    logic          ge;
    logic [9:0]    rem_new;
    logic [SW:0]   q2;
    logic [SW-1:0] qm_new;
    logic [SW-1:0] off;
    logic [SW:0]   s2;
    logic [SW-1:0] slot_fin;

    always_comb
    begin
        t       = {rem_reg, dvd_reg[15]};
        ge      = t >= {1'b0, dsr_reg};
        rem_new = ge ? 10'(t - {1'b0, dsr_reg}) : t[9:0];
        q2      = {qmod_reg, ge};
        qm_new  = (q2 >= W_EXT) ? SW'(q2 - W_EXT) : q2[SW-1:0];
        off     = qnz_reg ? qmod_reg : SW'(1);
        s2      = {1'b0, cur_reg} + {1'b0, off};
        slot_fin = (s2 >= W_EXT) ? SW'(s2 - W_EXT) : s2[SW-1:0];
    end

    always_comb
    begin
        busy_next = busy_reg;
        fin_next  = 1'b0;
        done_next = 1'b0;
        if (req.start)
        begin
            busy_next = 1'b1;
        end
        else if (busy_reg && cnt_reg == 4'd15)
        begin
            busy_next = 1'b0;
            fin_next  = 1'b1;
        end
        if (fin_reg)
        begin
            done_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            fin_reg  <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            fin_reg  <= fin_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            cnt_reg  <= '0;
            dvd_reg  <= req.dividend;
            dsr_reg  <= (req.divisor == 10'd0) ? 10'd1 : req.divisor;
            rem_reg  <= '0;
            qmod_reg <= '0;
            qnz_reg  <= 1'b0;
            cur_reg  <= cur;
        end
        else if (busy_reg)
        begin
            cnt_reg  <= cnt_reg + 4'd1;
            dvd_reg  <= {dvd_reg[14:0], 1'b0};
            rem_reg  <= rem_new;
            qmod_reg <= qm_new;
            qnz_reg  <= qnz_reg | ge;
        end
        if (fin_reg)
        begin
            slot_reg <= slot_fin;
        end
    end

    assign done = done_reg;
    assign slot = slot_reg;

endmodule

/* rtl/hashed_timer_wheel_top.sv */
// channel  dir  handshake              payload
// cfg      in   cfg_valid/cfg_ready    cfg_index (0 tick interval, 1 max timeout), cfg_data
// s        in   s_tvalid/s_tready      s_tuser req_type, s_tdata handle/timeout/user_tag
// m        out  m_tvalid/m_tready      m_tuser kind, m_tdata status/handle/tag, m_tlast
//
// one request at a time; s_tready is high only while the sequencer is idle
// add, restart and modify go through the 16-step slot divider
// remove, clear and rejected requests go straight to the acknowledgement
// a tick reads every entry and sends each repeating expiry back through the divider
// results leave through one output register; a stalled m side holds the sequencer
// reset clears running flags and current slot; entry memory is not cleared
module hashed_timer_wheel_top #(
    parameter int NUM_TIMERS = 32,
    parameter int SLOT_COUNT = 256
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [15:0] cfg_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [55:0] s_tdata,  // handle, timeout, user_tag, zero pad
    input  logic [2:0]  s_tuser,  // req_type
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,  // status, out_handle, out_tag, zero pad
    output logic [0:0]  m_tuser,  // kind
    output logic        m_tlast
);
    import htw_pkg::*;

    localparam int HW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
    localparam int SW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int DW = 1 + 16 + SW + 32;
    localparam logic [HW-1:0] IDX_LAST = HW'(NUM_TIMERS - 1);
    localparam logic [SW-1:0] SLOT_LAST = SW'(SLOT_COUNT - 1);

    state_t          state_reg, state_next;
    logic [9:0]      tick_reg, tick_next;
    logic [15:0]     max_reg, max_next;
    logic [NUM_TIMERS-1:0] running_reg, running_next;
    logic [SW-1:0]   cur_reg, cur_next;
    logic            pend_valid_reg, pend_valid_next;
    logic            out_valid_reg, out_valid_next;

    req_t            req_reg, req_next;
    logic [HW-1:0]   idx_reg, idx_next;
    logic [15:0]     tmo_reg, tmo_next;
    logic [31:0]     tag_reg, tag_next;
    logic [1:0]      ack_status_reg, ack_status_next;
    logic [4:0]      ack_handle_reg, ack_handle_next;
    logic [4:0]      pend_handle_reg, pend_handle_next;
    logic [31:0]     pend_tag_reg, pend_tag_next;
    logic            out_kind_reg;
    logic [1:0]      out_status_reg;
    logic [4:0]      out_handle_reg;
    logic [31:0]     out_tag_reg;
    logic            out_last_reg;

    logic            out_load, ol_kind, ol_last;
    logic [1:0]      ol_status;
    logic [4:0]      ol_handle;
    logic [31:0]     ol_tag;
    logic            out_free;

    req_t            in_req;
    logic [4:0]      in_h;
    logic [15:0]     in_tmo;
    logic [31:0]     in_tag;
    logic [6:0]      in_hext;
    logic [HW-1:0]   hidx;
    logic            in_h_ok;
    logic [HW-1:0]   free_idx;
    logic [6:0]      free_ext;
    logic [6:0]      idx_ext;

    logic            rd_en, wr_en;
    logic [DW-1:0]   rd_data, wr_data;
    logic            rd_rep;
    logic [15:0]     rd_tmo;
    logic [SW-1:0]   rd_slot;
    logic [31:0]     rd_tag;
    logic            match;

    div_req_t        div_req;
    logic            div_done;
    logic [SW-1:0]   div_slot;

    htw_ram #(.DEPTH(NUM_TIMERS), .AW(HW), .DW(DW)) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (idx_reg),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (idx_reg),
        .rd_data (rd_data)
    );

    htw_div #(.SW(SW), .SLOT_COUNT(SLOT_COUNT)) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .cur   (cur_reg),
        .done  (div_done),
        .slot  (div_slot)
    );

    assign in_req   = req_t'(s_tuser);
    assign in_h     = s_tdata[4:0];
    assign in_tmo   = s_tdata[20:5];
    assign in_tag   = s_tdata[52:21];
    assign in_hext  = {2'b00, in_h};
    assign hidx     = in_hext[HW-1:0];
    assign in_h_ok  = (in_hext < 7'(NUM_TIMERS)) && running_reg[hidx];
    assign free_ext = 7'(free_idx);
    assign idx_ext  = 7'(idx_reg);

    assign rd_rep  = rd_data[DW-1];
    assign rd_tmo  = rd_data[DW-2 -: 16];
    assign rd_slot = rd_data[32 +: SW];
    assign rd_tag  = rd_data[31:0];
    assign match   = running_reg[idx_reg] && (rd_slot == cur_reg);

    assign out_free  = !out_valid_reg || m_tready;
    assign s_tready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;

    // lowest free entry
    always_comb
    begin
        free_idx = '0;
        for (int i = NUM_TIMERS - 1; i >= 0; i--)
        begin
            if (!running_reg[i])
            begin
                free_idx = HW'(i);
            end
        end
    end

    always_comb
    begin
        tick_next = tick_reg;
        max_next  = max_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_TICK_INTERVAL: tick_next = cfg_data[9:0];
                CFG_MAX_TIMEOUT:   max_next  = cfg_data;
                default:           ;
            endcase
        end
    end

    always_comb
    begin
        state_next       = state_reg;
        running_next     = running_reg;
        cur_next         = cur_reg;
        pend_valid_next  = pend_valid_reg;
        req_next         = req_reg;
        idx_next         = idx_reg;
        tmo_next         = tmo_reg;
        tag_next         = tag_reg;
        ack_status_next  = ack_status_reg;
        ack_handle_next  = ack_handle_reg;
        pend_handle_next = pend_handle_reg;
        pend_tag_next    = pend_tag_reg;
        out_load         = 1'b0;
        ol_kind          = KIND_ACK;
        ol_status        = ST_OK;
        ol_handle        = '0;
        ol_tag           = '0;
        ol_last          = 1'b1;
        rd_en            = 1'b0;
        wr_en            = 1'b0;
        wr_data          = '0;
        div_req.start    = 1'b0;
        div_req.dividend = tmo_reg;
        div_req.divisor  = tick_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    req_next        = in_req;
                    tmo_next        = in_tmo;
                    tag_next        = in_tag;
                    idx_next        = hidx;
                    ack_status_next = ST_OK;
                    ack_handle_next = in_h;
                    case (in_req) inside
                        REQ_TICK:
                        begin
                            cur_next   = (cur_reg == SLOT_LAST) ? '0 : cur_reg + SW'(1);
                            idx_next   = '0;
                            state_next = S_TREAD;
                        end
                        REQ_ADD_ONE, REQ_ADD_REP:
                        begin
                            ack_handle_next = '0;
                            if (in_tmo == 16'd0 || in_tmo >= max_reg)
                            begin
                                ack_status_next = ST_BAD_TMO;
                                state_next      = S_ACK;
                            end
                            else if (&running_reg)
                            begin
                                ack_status_next = ST_FULL;
                                state_next      = S_ACK;
                            end
                            else
                            begin
                                idx_next         = free_idx;
                                ack_handle_next  = free_ext[4:0];
                                div_req.start    = 1'b1;
                                div_req.dividend = in_tmo;
                                state_next       = S_DIV;
                            end
                        end
                        REQ_REMOVE, REQ_RESTART, REQ_MODIFY:
                        begin
                            if (!in_h_ok)
                            begin
                                ack_status_next = ST_NOT_RUN;
                                state_next      = S_ACK;
                            end
                            else if (in_req == REQ_REMOVE)
                            begin
                                running_next[hidx] = 1'b0;
                                state_next         = S_ACK;
                            end
                            else
                            begin
                                state_next = S_TREAD;
                            end
                        end
                        REQ_CLEAR:
                        begin
                            running_next    = '0;
                            ack_handle_next = '0;
                            state_next      = S_ACK;
                        end
                        default: ;
                    endcase
                end
            end
            S_TREAD:
            begin
                rd_en      = 1'b1;
                state_next = S_TCHK;
            end
            S_TCHK:
            begin
                if (req_reg == REQ_TICK)
                begin
                    if (!match)
                    begin
                        if (idx_reg == IDX_LAST)
                        begin
                            state_next = S_FLUSH;
                        end
                        else
                        begin
                            idx_next   = idx_reg + HW'(1);
                            state_next = S_TREAD;
                        end
                    end
                    else if (!pend_valid_reg || out_free)
                    begin
                        // previous expiry goes out now that another follows it
                        if (pend_valid_reg)
                        begin
                            out_load  = 1'b1;
                            ol_kind   = KIND_EXPIRY;
                            ol_handle = pend_handle_reg;
                            ol_tag    = pend_tag_reg;
                            ol_last   = 1'b0;
                        end
                        pend_valid_next  = 1'b1;
                        pend_handle_next = idx_ext[4:0];
                        pend_tag_next    = rd_tag;
                        if (rd_rep)
                        begin
                            tmo_next         = rd_tmo;
                            div_req.start    = 1'b1;
                            div_req.dividend = rd_tmo;
                            state_next       = S_DIV;
                        end
                        else
                        begin
                            running_next[idx_reg] = 1'b0;
                            if (idx_reg == IDX_LAST)
                            begin
                                state_next = S_FLUSH;
                            end
                            else
                            begin
                                idx_next   = idx_reg + HW'(1);
                                state_next = S_TREAD;
                            end
                        end
                    end
                end
                else
                begin
                    if (req_reg == REQ_RESTART)
                    begin
                        tmo_next         = rd_tmo;
                        div_req.dividend = rd_tmo;
                    end
                    div_req.start = 1'b1;
                    state_next    = S_DIV;
                end
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    state_next = S_WRITE;
                end
            end
            S_WRITE:
            begin
                wr_en = 1'b1;
                if (req_reg == REQ_ADD_ONE || req_reg == REQ_ADD_REP)
                begin
                    wr_data = {req_reg == REQ_ADD_REP, tmo_reg, div_slot, tag_reg};
                    running_next[idx_reg] = 1'b1;
                    state_next = S_ACK;
                end
                else
                begin
                    wr_data = {rd_rep, tmo_reg, div_slot, rd_tag};
                    if (req_reg == REQ_TICK)
                    begin
                        if (idx_reg == IDX_LAST)
                        begin
                            state_next = S_FLUSH;
                        end
                        else
                        begin
                            idx_next   = idx_reg + HW'(1);
                            state_next = S_TREAD;
                        end
                    end
                    else
                    begin
                        state_next = S_ACK;
                    end
                end
            end
            S_ACK:
            begin
                if (out_free)
                begin
                    out_load   = 1'b1;
                    ol_status  = ack_status_reg;
                    ol_handle  = ack_handle_reg;
                    state_next = S_IDLE;
                end
            end
            S_FLUSH:
            begin
                if (!pend_valid_reg)
                begin
                    state_next = S_IDLE;
                end
                else if (out_free)
                begin
                    out_load        = 1'b1;
                    ol_kind         = KIND_EXPIRY;
                    ol_handle       = pend_handle_reg;
                    ol_tag          = pend_tag_reg;
                    pend_valid_next = 1'b0;
                    state_next      = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase

        out_valid_next = out_load ? 1'b1 : (m_tready ? 1'b0 : out_valid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            tick_reg       <= 10'd10;
            max_reg        <= 16'hFFFF;
            running_reg    <= '0;
            cur_reg        <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            tick_reg       <= tick_next;
            max_reg        <= max_next;
            running_reg    <= running_next;
            cur_reg        <= cur_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg         <= req_next;
        idx_reg         <= idx_next;
        tmo_reg         <= tmo_next;
        tag_reg         <= tag_next;
        ack_status_reg  <= ack_status_next;
        ack_handle_reg  <= ack_handle_next;
        pend_handle_reg <= pend_handle_next;
        pend_tag_reg    <= pend_tag_next;
        if (out_load)
        begin
            out_kind_reg   <= ol_kind;
            out_status_reg <= ol_status;
            out_handle_reg <= ol_handle;
            out_tag_reg    <= ol_tag;
            out_last_reg   <= ol_last;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, out_tag_reg, out_handle_reg, out_status_reg};
    assign m_tuser  = out_kind_reg;
    assign m_tlast  = out_last_reg;

    a_div_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> state_reg == S_DIV)
        else $error("divider result outside wait state");

    a_no_pend_idle: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_IDLE |-> !pend_valid_reg)
        else $error("expiry left pending in idle");

    a_tick_moves: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && s_tuser == REQ_TICK) |=> cur_reg != $past(cur_reg))
        else $error("tick did not advance current slot");

endmodule

/* bench/hashed_timer_wheel_top_test.sv */
`timescale 1ns / 1ps

module hashed_timer_wheel_top_test;
    import htw_pkg::*;

    localparam int POOL = 32;
    localparam int SLOTS = 256;
    localparam logic [2:0] REQ_UNUSED = 3'd7;
    localparam int SETTLE_CYCLES = 200;

    typedef struct {
        logic        kind;
        logic [1:0]  status;
        logic [4:0]  handle;
        logic [31:0] tag;
        logic        last;
    } timer_result_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic        cfg_index = 1'b0;
    logic [15:0] cfg_data = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [55:0] s_tdata = '0;  // handle, timeout, user_tag, zero pad
    logic [2:0]  s_tuser = '0;  // req_type
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;  // status, out_handle, out_tag, zero pad
    logic [0:0]  m_tuser;  // kind
    logic        m_tlast;

    // shadow of the timer pool
    bit          entry_live [POOL];
    bit          timer_repeat [POOL];
    logic [15:0] timer_tmo [POOL];
    logic [7:0]  timer_slot [POOL];
    logic [31:0] timer_tag [POOL];
    logic [7:0]  wheel_pos = '0;
    logic [9:0]  tick_ms = 10'd10;
    logic [15:0] tmo_limit = 16'hFFFF;

    timer_result_t pending_results[$];
    int mismatches = 0;
    int items_sent = 0;
    int results_seen = 0;
    int send_idle_pct = 28;
    int recv_idle_pct = 70;
    int hold_cycles = 0;

    hashed_timer_wheel_top u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic logic [7:0] slot_after(logic [15:0] tmo);
        int divisor;
        int offset;
        divisor = (tick_ms == 0) ? 1 : int'(tick_ms);
        offset = int'(tmo) / divisor;
        if (offset < 1)
        begin
            offset = 1;
        end
        return 8'((int'(wheel_pos) + offset) % SLOTS);
    endfunction

    function automatic void push_result(logic kind, logic [1:0] status, logic [4:0] h,
                                        logic [31:0] tag, logic last);
        timer_result_t r;
        r.kind = kind;
        r.status = status;
        r.handle = h;
        r.tag = tag;
        r.last = last;
        pending_results.push_back(r);
    endfunction

    function automatic void predict_wheel(logic [2:0] req, logic [4:0] h, logic [15:0] tmo,
                                          logic [31:0] tag);
        int fired;
        fired = 0;
        case (req)
            REQ_TICK:
            begin
                wheel_pos = wheel_pos + 8'd1;
                for (int i = 0; i < POOL; i++)
                begin
                    if (entry_live[i] && timer_slot[i] == wheel_pos)
                    begin
                        push_result(KIND_EXPIRY, ST_OK, 5'(i), timer_tag[i], 1'b0);
                        fired++;
                        if (timer_repeat[i])
                        begin
                            timer_slot[i] = slot_after(timer_tmo[i]);
                        end
                        else
                        begin
                            entry_live[i] = 1'b0;
                        end
                    end
                end
                if (fired > 0)
                begin
                    pending_results[$].last = 1'b1;
                end
            end
            REQ_ADD_ONE, REQ_ADD_REP:
            begin
                if (tmo == 0 || tmo >= tmo_limit)
                begin
                    push_result(KIND_ACK, ST_BAD_TMO, '0, '0, 1'b1);
                end
                else
                begin
                    for (int i = 0; i < POOL; i++)
                    begin
                        if (!entry_live[i] && fired == 0)
                        begin
                            entry_live[i] = 1'b1;
                            timer_repeat[i] = (req == REQ_ADD_REP);
                            timer_tmo[i] = tmo;
                            timer_tag[i] = tag;
                            timer_slot[i] = slot_after(tmo);
                            push_result(KIND_ACK, ST_OK, 5'(i), '0, 1'b1);
                            fired = 1;
                        end
                    end
                    if (fired == 0)
                    begin
                        push_result(KIND_ACK, ST_FULL, '0, '0, 1'b1);
                    end
                end
            end
            REQ_REMOVE, REQ_RESTART, REQ_MODIFY:
            begin
                if (!entry_live[h])
                begin
                    push_result(KIND_ACK, ST_NOT_RUN, h, '0, 1'b1);
                end
                else
                begin
                    if (req == REQ_REMOVE)
                    begin
                        entry_live[h] = 1'b0;
                    end
                    else
                    begin
                        if (req == REQ_MODIFY)
                        begin
                            timer_tmo[h] = tmo;
                        end
                        timer_slot[h] = slot_after(timer_tmo[h]);
                    end
                    push_result(KIND_ACK, ST_OK, h, '0, 1'b1);
                end
            end
            REQ_CLEAR:
            begin
                for (int i = 0; i < POOL; i++)
                begin
                    entry_live[i] = 1'b0;
                end
                push_result(KIND_ACK, ST_OK, '0, '0, 1'b1);
            end
            default:
            begin
            end
        endcase
    endfunction

    task automatic flag_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
        mismatches++;
    endtask

    // result checker
    always @(posedge clk)
    begin
        timer_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            results_seen++;
            if (pending_results.size() == 0)
            begin
                flag_mismatch("unexpected item", m_tdata[38:7], '0);
            end
            else
            begin
                want = pending_results.pop_front();
                if (m_tuser[0] !== want.kind)
                    flag_mismatch("kind", m_tuser[0], want.kind);
                if (m_tdata[1:0] !== want.status)
                    flag_mismatch("status", m_tdata[1:0], want.status);
                if (m_tdata[6:2] !== want.handle)
                    flag_mismatch("handle", m_tdata[6:2], want.handle);
                if (m_tdata[38:7] !== want.tag)
                    flag_mismatch("tag", m_tdata[38:7], want.tag);
                if (m_tlast !== want.last)
                    flag_mismatch("last", m_tlast, want.last);
            end
        end
    end

    // receiver readiness
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
        end
        else if (hold_cycles > 0)
        begin
            m_tready <= 1'b0;
            hold_cycles--;
        end
        else
        begin
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    task automatic send_item(logic [2:0] req, logic [4:0] h, logic [15:0] tmo,
                             logic [31:0] tag);
        if ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < send_idle_pct)
            begin
                @(posedge clk);
            end
        end
        s_tvalid <= 1'b1;
        s_tuser <= req;
        s_tdata <= {3'b000, tag, tmo, h};
        do
        begin
            @(posedge clk);
        end
        while (!s_tready);
        predict_wheel(req, h, tmo, tag);
        items_sent++;
    endtask

    task automatic drain;
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(logic idx, logic [15:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        do
        begin
            @(posedge clk);
        end
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge clk);
        if (idx == CFG_TICK_INTERVAL)
            tick_ms = value[9:0];
        else
            tmo_limit = value;
    endtask

    task automatic set_config(logic [15:0] tick_value, logic [15:0] limit_value);
        drain();
        write_reg(CFG_TICK_INTERVAL, tick_value);
        write_reg(CFG_MAX_TIMEOUT, limit_value);
    endtask

    function automatic logic [4:0] pick_handle;
        int live[$];
        for (int i = 0; i < POOL; i++)
        begin
            if (entry_live[i])
                live.push_back(i);
        end
        if (live.size() > 0 && $urandom_range(99) < 80)
            return 5'(live[$urandom_range(live.size() - 1)]);
        return 5'($urandom_range(POOL - 1));
    endfunction

    task automatic random_item;
        int pick;
        int span;
        logic [15:0] tmo;
        pick = $urandom_range(99);
        span = (tick_ms == 0 ? 1 : int'(tick_ms)) * 12;
        if (span > 65535)
            span = 65535;
        tmo = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(span, 1));
        if (pick < 40)
            send_item(REQ_TICK, 5'($urandom), 16'($urandom), $urandom);
        else if (pick < 62)
            send_item($urandom_range(1) ? REQ_ADD_REP : REQ_ADD_ONE, 5'($urandom), tmo,
                      $urandom);
        else if (pick < 90)
            send_item(3'($urandom_range(REQ_MODIFY, REQ_REMOVE)), pick_handle(), tmo, $urandom);
        else if (pick < 93)
            send_item(REQ_CLEAR, 5'($urandom), 16'($urandom), $urandom);
        else if (pick < 95)
            send_item(REQ_UNUSED, 5'($urandom), 16'($urandom), $urandom);
        else
            send_item(3'($urandom), 5'($urandom), 16'($urandom), $urandom);
    endtask

    task automatic test_directed;
        send_item(REQ_ADD_ONE, 5'd0, 16'd0, 32'h1234_5678);
        send_item(REQ_ADD_REP, 5'd0, 16'hFFFF, 32'h1);
        send_item(REQ_ADD_ONE, 5'd0, 16'd10, 32'hFFFF_FFFF);
        send_item(REQ_ADD_REP, 5'd0, 16'd25, 32'h0);
        send_item(REQ_ADD_ONE, 5'd0, 16'hFFFE, $urandom);
        send_item(REQ_TICK, 5'd0, 16'd0, 32'd0);
        send_item(REQ_TICK, 5'd31, 16'hFFFF, 32'hFFFF_FFFF);
        send_item(REQ_RESTART, 5'd1, 16'd0, 32'd0);
        send_item(REQ_MODIFY, 5'd2, 16'd0, 32'd0);
        send_item(REQ_TICK, 5'd0, 16'd0, 32'd0);
        send_item(REQ_TICK, 5'd0, 16'd0, 32'd0);
        send_item(REQ_REMOVE, 5'd1, 16'd0, 32'd0);
        send_item(REQ_REMOVE, 5'd1, 16'd0, 32'd0);
        send_item(REQ_RESTART, 5'd5, 16'd0, 32'd0);
        send_item(REQ_MODIFY, 5'd31, 16'hFFFF, 32'd0);
        send_item(REQ_UNUSED, 5'd31, 16'hFFFF, 32'hFFFF_FFFF);
        send_item(REQ_ADD_REP, 5'd0, 16'd1, 32'hA5A5_5A5A);
        send_item(REQ_ADD_ONE, 5'd0, 16'd9, 32'h5A5A_A5A5);
        send_item(REQ_TICK, 5'd0, 16'd0, 32'd0);
        send_item(REQ_CLEAR, 5'd0, 16'd0, 32'd0);
        send_item(REQ_TICK, 5'd0, 16'd0, 32'd0);
    endtask

    task automatic test_pool_full;
        for (int i = 0; i < POOL; i++)
            send_item(i % 2 ? REQ_ADD_REP : REQ_ADD_ONE, 5'd0, 16'hFFFE, $urandom);
        send_item(REQ_ADD_ONE, 5'd0, 16'd100, $urandom);
        send_item(REQ_CLEAR, 5'd0, 16'd0, 32'd0);
    endtask

    task automatic test_full_revolution;
        set_config(16'd1, 16'hFFFF);
        send_item(REQ_ADD_ONE, 5'd0, 16'd256, 32'hCAFE_0001);
        send_item(REQ_ADD_REP, 5'd0, 16'd512, 32'hCAFE_0002);
        send_item(REQ_ADD_REP, 5'd0, 16'd3, 32'hCAFE_0003);
        for (int i = 0; i < SLOTS; i++)
            send_item(REQ_TICK, 5'd0, 16'd0, 32'd0);
        send_item(REQ_CLEAR, 5'd0, 16'd0, 32'd0);
    endtask

    task automatic test_config_settings;
        logic [15:0] ticks [4] = '{16'd0, 16'hFFFF, 16'd1000, 16'd1};
        logic [15:0] limits [4] = '{16'd1, 16'hFFFF, 16'd300, 16'd2};
        for (int k = 0; k < 4; k++)
        begin
            set_config(ticks[k], limits[k]);
            send_item(REQ_ADD_REP, 5'd0, 16'd1, $urandom);
            send_item(REQ_ADD_ONE, 5'd0, limits[k] - 16'd1, $urandom);
            send_item(REQ_ADD_ONE, 5'd0, limits[k], $urandom);
        end
    endtask

    task automatic test_backpressure;
        set_config(16'd4, 16'd200);
        hold_cycles = 400;
        for (int i = 0; i < 8; i++)
            send_item(i < 4 ? REQ_ADD_REP : REQ_TICK, 5'd0, 16'($urandom_range(1, 8)), $urandom);
    endtask

    task automatic test_random_traffic;
        int send_pcts [3] = '{28, 70, 0};
        int recv_pcts [3] = '{70, 28, 0};
        for (int p = 0; p < 3; p++)
        begin
            set_config(16'($urandom_range(20, 1)), 16'($urandom_range(65535, 100)));
            send_idle_pct = send_pcts[p];
            recv_idle_pct = recv_pcts[p];
            repeat (5) random_item();
        end
    endtask

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_pool_full();
        test_full_revolution();
        test_config_settings();
        test_backpressure();
        test_random_traffic();
        drain();
        $display("sent %0d requests, checked %0d results", items_sent, results_seen);
        $display("covered adds, removes, restarts, modifies, ticks, clears and limit settings");
        if (mismatches == 0)
        begin
            $display("end of test: clean");
        end
        else
        begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    initial
    begin
        #16ms;
        $display("timeout waiting for results");
        $display("end of test: mismatches");
        $finish;
    end

endmodule

/* filelist.f */
rtl/htw_pkg.sv
rtl/htw_ram.sv
rtl/htw_div.sv
rtl/hashed_timer_wheel_top.sv
bench/hashed_timer_wheel_top_test.sv
